### design/top_k_nearest_vote_macros.svh
// assertion helpers for the top-k vote block
`ifndef TOP_K_NEAREST_VOTE_MACROS_SVH
`define TOP_K_NEAREST_VOTE_MACROS_SVH
// implication checked on every edge out of reset
`define TKV_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tkv check failed");
// implication checked in the cycle after the antecedent
`define TKV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tkv check failed");
`endif

### design/tkv_pkg.sv
// ----------------------------------------------------------------------------
// tkv_pkg
// types and constants shared by the top-k vote block
// ----------------------------------------------------------------------------
`default_nettype none
package tkv_pkg;
    localparam int K_MAX       = 8;
    localparam int NCLASS_MAX  = 16;
    localparam int SCORE_WIDTH = 32;
    localparam int RANK_W      = 3;
    localparam int LABEL_W     = 4;
    localparam int INDEX_W     = 24;
    localparam int CNT_W       = 4;
    localparam int SUM_W       = 36;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;

    localparam logic [1:0] CFG_FIND_MAX    = 2'd0;
    localparam logic [1:0] CFG_K_IN_USE    = 2'd1;
    localparam logic [1:0] CFG_CLASS_COUNT = 2'd2;

    typedef struct packed {
        logic                          start_req;
        logic signed [SCORE_WIDTH-1:0] score;
        logic [LABEL_W-1:0]            label;
        logic [INDEX_W-1:0]            sample_index;
        logic                          last;
    } t_in;

    typedef struct packed {
        logic [RANK_W-1:0]             rank;
        logic                          entry_valid;
        logic signed [SCORE_WIDTH-1:0] entry_score;
        logic [LABEL_W-1:0]            entry_label;
        logic [INDEX_W-1:0]            entry_index;
        logic [LABEL_W-1:0]            majority_class;
        logic [LABEL_W-1:0]            weighted_class;
        logic                          last_of_run;
    } t_out;

    // queue status seen by the back end
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;
endpackage
`default_nettype wire

### design/tkv_front.sv
// ----------------------------------------------------------------------------
// tkv_front
// accepts command beats into a short queue and hands them to the back end
// ----------------------------------------------------------------------------
`default_nettype none
module tkv_front import tkv_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_in  i_data,
    input  wire logic i_pop,
    output t_in       o_data,
    output t_q_stat   o_stat
);
    t_in                r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QPTR_W:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + {{QPTR_W{1'b0}}, i_push} - {{QPTR_W{1'b0}}, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
endmodule
`default_nettype wire

### design/tkv_back.sv
// ----------------------------------------------------------------------------
// tkv_back
// ranked insertion list, vote tally and per-rank result emission
// ----------------------------------------------------------------------------
`default_nettype none
`include "top_k_nearest_vote_macros.svh"
module tkv_back import tkv_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_find_max,
    input  wire logic [RANK_W:0]    i_k,
    input  wire logic [LABEL_W:0]   i_nc,
    input  wire t_q_stat            i_stat,
    input  wire t_in                i_data,
    output logic                    o_pop,
    output logic                    o_busy,
    output logic                    o_valid,
    output t_out                    o_data
);
    typedef enum logic [1:0] {S_RUN, S_TALLY, S_VOTE, S_EMIT} t_state;

    t_state r_state;
    logic signed [SCORE_WIDTH-1:0] r_score [K_MAX];
    logic [LABEL_W-1:0]            r_label [K_MAX];
    logic [INDEX_W-1:0]            r_index [K_MAX];
    logic [K_MAX-1:0]              r_vld;
    logic [CNT_W-1:0]              r_cnt   [NCLASS_MAX];
    logic signed [SUM_W-1:0]       r_sum   [NCLASS_MAX];
    logic [RANK_W-1:0]             r_i;
    logic [LABEL_W-1:0]            r_c, r_maj, r_wgt;
    logic                          r_valid;
    t_out                          r_out;

    // insertion on the list after optional clear
    logic [K_MAX-1:0] pass, cur_vld;
    logic [K_MAX-1:0] pass_ok;
    always_comb begin
        cur_vld = i_data.start_req ? '0 : r_vld;
        for (int r = 0; r < K_MAX; r++) begin
            pass[r] = !cur_vld[r] ||
                (i_find_max ? (r_score[r] <= i_data.score) : (r_score[r] >= i_data.score));
        end
        // rank r may take the item when all ranks r..k-1 may be passed
        for (int r = K_MAX-1; r >= 0; r--) begin
            if (r >= 32'(i_k)) pass_ok[r] = 1'b0;
            else if (r == 32'(i_k) - 1) pass_ok[r] = pass[r];
            else pass_ok[r] = pass[r] && pass_ok[r+1];
        end
    end

    logic take;
    assign take  = (r_state == S_RUN) && !i_stat.empty;
    assign o_pop = take;
    assign o_busy = i_stat.full;

    logic [RANK_W:0] kl;
    assign kl = i_k - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_RUN: begin
                    if (take) begin
                        for (int r = 0; r < K_MAX; r++) begin
                            if (r < 32'(i_k)) begin
                                if (pass_ok[r]) begin
                                    if (r == 0 || !pass_ok[r-1]) begin
                                        r_vld[r]   <= 1'b1;
                                        r_score[r] <= i_data.score;
                                        r_label[r] <= i_data.label;
                                        r_index[r] <= i_data.sample_index;
                                    end else begin
                                        r_vld[r]   <= cur_vld[r-1];
                                        r_score[r] <= r_score[r-1];
                                        r_label[r] <= r_label[r-1];
                                        r_index[r] <= r_index[r-1];
                                    end
                                end else begin
                                    r_vld[r] <= cur_vld[r];
                                end
                            end else begin
                                r_vld[r] <= cur_vld[r];
                            end
                        end
                        if (i_data.start_req) begin
                            for (int r = 0; r < K_MAX; r++) begin
                                if (!(r < 32'(i_k) && pass_ok[r])) begin
                                    r_score[r] <= '0;
                                    r_label[r] <= '0;
                                    r_index[r] <= '0;
                                end
                            end
                        end
                        if (i_data.last) begin
                            for (int c = 0; c < NCLASS_MAX; c++) begin
                                r_cnt[c] <= '0;
                                r_sum[c] <= '0;
                            end
                            r_i     <= '0;
                            r_state <= S_TALLY;
                        end
                    end
                end
                S_TALLY: begin
                    if (r_vld[r_i] && ({1'b0, r_label[r_i]} < i_nc)) begin
                        r_cnt[r_label[r_i]] <= r_cnt[r_label[r_i]] + 1'b1;
                        r_sum[r_label[r_i]] <= r_sum[r_label[r_i]] + SUM_W'(r_score[r_i]);
                    end
                    if ({1'b0, r_i} == kl) begin
                        r_c     <= '0;
                        r_maj   <= '0;
                        r_wgt   <= '0;
                        r_state <= S_VOTE;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_VOTE: begin
                    if (r_cnt[r_c] > r_cnt[r_maj]) r_maj <= r_c;
                    if (r_sum[r_c] > r_sum[r_wgt]) r_wgt <= r_c;
                    if ({1'b0, r_c} == i_nc - 1'b1) begin
                        r_i     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_EMIT: begin
                    r_valid                <= 1'b1;
                    r_out.rank             <= r_i;
                    r_out.entry_valid      <= r_vld[r_i];
                    r_out.entry_score      <= r_vld[r_i] ? r_score[r_i] : '0;
                    r_out.entry_label      <= r_vld[r_i] ? r_label[r_i] : '0;
                    r_out.entry_index      <= r_vld[r_i] ? r_index[r_i] : '0;
                    r_out.majority_class   <= r_maj;
                    r_out.weighted_class   <= r_wgt;
                    r_out.last_of_run      <= ({1'b0, r_i} == kl);
                    if ({1'b0, r_i} == kl) r_state <= S_RUN;
                    else r_i <= r_i + 1'b1;
                end
                default: r_state <= S_RUN;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

    `TKV_ASSERT_IMP(a_no_pop_empty, o_pop, !i_stat.empty)
    `TKV_ASSERT_IMP(a_pop_only_run, o_pop, r_state == S_RUN)
    `TKV_ASSERT_NEXT(a_emit_strobe, r_state == S_EMIT, o_valid)
    `TKV_ASSERT_IMP(a_last_rank, o_valid && o_data.last_of_run, {1'b0, o_data.rank} == kl)
endmodule
`default_nettype wire

### design/top_k_nearest_vote.sv
// ----------------------------------------------------------------------------
// top_k_nearest_vote
// top-k ranked insertion list with majority and score-weighted class votes
// ----------------------------------------------------------------------------
// A beat is taken when i_start is high and o_busy low; beats go into a
// four-deep queue and, in its run state, the back end inserts one per cycle
// into the ranked list. A beat with last makes the back end tally the k
// ranks, scan the class_count classes for the votes, then strobe k results,
// one per cycle on o_strobe; the receiver cannot stall, so each result is seen
// only in its one strobe cycle. During tally, vote and emit no queued beat is
// consumed, and o_busy rises once the queue fills. Configuration must be
// written through i_cfg_we / i_cfg_idx / i_cfg_data only while idle; the
// block itself does not enforce this. Out-of-range k and class counts are
// clamped here.
`default_nettype none
module top_k_nearest_vote import tkv_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire t_in        i_data,
    output logic            o_strobe,
    output t_out            o_result,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [4:0] i_cfg_data
);
    logic       r_find_max;
    logic [3:0] r_k_in_use;
    logic [4:0] r_class_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_find_max    <= 1'b1;
            r_k_in_use    <= 4'd8;
            r_class_count <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIND_MAX:    r_find_max    <= i_cfg_data[0];
                CFG_K_IN_USE:    r_k_in_use    <= i_cfg_data[3:0];
                CFG_CLASS_COUNT: r_class_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp to the supported ranges
    logic [RANK_W:0]  k_eff;
    logic [LABEL_W:0] nc_eff;
    assign k_eff  = (r_k_in_use == '0) ? 4'd1 :
                    (r_k_in_use > 4'(K_MAX)) ? 4'(K_MAX) : r_k_in_use;
    assign nc_eff = (r_class_count == '0) ? 5'd1 :
                    (r_class_count > 5'(NCLASS_MAX)) ? 5'(NCLASS_MAX) : r_class_count;

    logic    push, pop, busy;
    t_in     q_data;
    t_q_stat q_stat;

    assign push   = i_start && !busy;
    assign o_busy = busy;

    tkv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_data),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_stat  (q_stat)
    );

    tkv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_find_max (r_find_max),
        .i_k        (k_eff),
        .i_nc       (nc_eff),
        .i_stat     (q_stat),
        .i_data     (q_data),
        .o_pop      (pop),
        .o_busy     (busy),
        .o_valid    (o_strobe),
        .o_data     (o_result)
    );
endmodule
`default_nettype wire
